@@ rtl/core/ltc_pkg.sv @@
// Shared types, constants and classification helpers for the token classifier.
package ltc_pkg;

	// Longest token length the counter tracks; the length saturates here.
	localparam int unsigned MAX_TOKEN_LEN = 64;
	localparam int unsigned LEN_W = 7;
	// Number of leading token characters kept for keyword matching.
	localparam int unsigned PREFIX_DEPTH = 6;
	localparam int unsigned PIDX_W = 3;
	// Depth of the event queue between front and back.
	localparam int unsigned EVQ_DEPTH = 4;
	localparam int unsigned EVQ_PTR_W = 2;
	localparam int unsigned EVQ_CNT_W = 3;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

	typedef enum logic [2:0] {
		KIND_KEYWORD = 3'd0,
		KIND_INTEGER = 3'd1,
		KIND_STRING  = 3'd2,
		KIND_CHAR    = 3'd3,
		KIND_LOGIC   = 3'd4,
		KIND_REAL    = 3'd5,
		KIND_IDENT   = 3'd6,
		KIND_OPER    = 3'd7
	} kind_t;

	// Word constants, first character in the lowest byte.
	localparam prefix_t KW_INT    = {8'h00, 8'h00, 8'h00, "t", "n", "i"};
	localparam prefix_t KW_FLOAT  = {8'h00, "t", "a", "o", "l", "f"};
	localparam prefix_t KW_STRING = {"g", "n", "i", "r", "t", "s"};
	localparam prefix_t KW_CHAR   = {8'h00, 8'h00, "r", "a", "h", "c"};
	localparam prefix_t KW_VOID   = {8'h00, 8'h00, "d", "i", "o", "v"};
	localparam prefix_t SY_AND    = {8'h00, 8'h00, 8'h00, 8'h00, "&", "&"};
	localparam prefix_t SY_OR     = {8'h00, 8'h00, 8'h00, 8'h00, "|", "|"};
	localparam prefix_t SY_NOT    = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "!"};

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] symbol_char;
		len_t       token_length;
		logic       last_of_run;
	} out_item_t;

	// One request from front to back: a closed token and/or an operator.
	typedef struct packed {
		logic       has_tok;
		kind_t      tok_kind;
		len_t       tok_len;
		logic       has_op;
		logic [7:0] op_char;
	} event_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} cls_t;

	function automatic logic is_operator(logic [7:0] c);
		logic r;
		unique case (c)
			"+", "-", "*", "/", ">", "<", "=", "(", ")", "[", "]", "{", "}": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_delim(logic [7:0] c);
		return is_operator(c) || c == " " || c == "," || c == ";";
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Exact match of the pending token against a short word.
	function automatic logic word_match(prefix_t p, len_t n, prefix_t w, len_t wl);
		logic m;
		m = (n == wl);
		for (int i = 0; i < PREFIX_DEPTH; i++) begin
			if (LEN_W'(i) < wl && p[i] != w[i])
				m = 1'b0;
		end
		return m;
	endfunction

	// Class of a non-empty token, tested in priority order.
	function automatic cls_t classify(prefix_t p, len_t n, logic all_dig,
			logic dig_dot, logic dot);
		cls_t r;
		r.valid = 1'b1;
		r.kind  = KIND_KEYWORD;
		priority if (word_match(p, n, KW_INT, LEN_W'(3)) ||
				word_match(p, n, KW_FLOAT, LEN_W'(5)) ||
				word_match(p, n, KW_STRING, LEN_W'(6)) ||
				word_match(p, n, KW_CHAR, LEN_W'(4)) ||
				word_match(p, n, KW_VOID, LEN_W'(4))) begin
			r.kind = KIND_KEYWORD;
		end else if (all_dig) begin
			r.kind = KIND_INTEGER;
		end else if (p[0] == 8'h22) begin
			r.kind = KIND_STRING;
		end else if (p[0] == 8'h27) begin
			r.kind = KIND_CHAR;
		end else if (word_match(p, n, SY_AND, LEN_W'(2)) ||
				word_match(p, n, SY_OR, LEN_W'(2)) ||
				word_match(p, n, SY_NOT, LEN_W'(1))) begin
			r.kind = KIND_LOGIC;
		end else if (dig_dot && dot) begin
			r.kind = KIND_REAL;
		end else if (!is_digit(p[0])) begin
			r.kind = KIND_IDENT;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/ltc_front.sv @@
// Front end: tracks the pending token and emits close/operator requests.
module ltc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ltc_pkg::in_item_t item,
	output logic              full,
	output logic              ev_push,
	output ltc_pkg::event_t   ev_data,
	input  logic              ev_full
);
	import ltc_pkg::*;

	len_t    count_q;
	prefix_t prefix_q;
	logic    all_dig_q, dig_dot_q, dot_q;

	logic       accept, delim, closing;
	logic [7:0] c;
	len_t       count_app, count_cls;
	prefix_t    prefix_app, prefix_cls;
	logic       all_dig_app, dig_dot_app, dot_app;
	logic       all_dig_cls, dig_dot_cls, dot_cls;
	cls_t       cls;

	assign full   = ev_full;
	assign accept = push && !ev_full;
	assign c      = item.char_code;
	assign delim  = is_delim(c);
	assign closing = delim || item.end_of_text;

	// Token state with the current character appended
	always_comb begin
		prefix_app = prefix_q;
		if (count_q < LEN_W'(PREFIX_DEPTH))
			prefix_app[count_q[PIDX_W-1:0]] = c;
		count_app   = (count_q < LEN_W'(MAX_TOKEN_LEN)) ? count_q + LEN_W'(1) : count_q;
		all_dig_app = all_dig_q && is_digit(c);
		dig_dot_app = dig_dot_q && (is_digit(c) || c == ".");
		dot_app     = dot_q || c == ".";
	end

	// A delimiter closes the token as it stood; end of text closes it after the append
	always_comb begin
		prefix_cls  = delim ? prefix_q  : prefix_app;
		count_cls   = delim ? count_q   : count_app;
		all_dig_cls = delim ? all_dig_q : all_dig_app;
		dig_dot_cls = delim ? dig_dot_q : dig_dot_app;
		dot_cls     = delim ? dot_q     : dot_app;
		cls = classify(prefix_cls, count_cls, all_dig_cls, dig_dot_cls, dot_cls);
	end

	// Request toward the back end
	always_comb begin
		ev_data.has_tok  = closing && count_cls != '0 && cls.valid;
		ev_data.tok_kind = cls.kind;
		ev_data.tok_len  = count_cls;
		ev_data.has_op   = is_operator(c);
		ev_data.op_char  = c;
		ev_push = accept && (ev_data.has_tok || ev_data.has_op);
	end

	// Pending token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			all_dig_q <= 1'b1;
			dig_dot_q <= 1'b1;
			dot_q     <= 1'b0;
		end else if (accept) begin
			if (closing) begin
				count_q   <= '0;
				all_dig_q <= 1'b1;
				dig_dot_q <= 1'b1;
				dot_q     <= 1'b0;
			end else begin
				count_q   <= count_app;
				all_dig_q <= all_dig_app;
				dig_dot_q <= dig_dot_app;
				dot_q     <= dot_app;
			end
		end
	end

	// Prefix bytes, written only for the pending token
	always_ff @(posedge clk) begin
		if (accept && !delim)
			prefix_q <= prefix_app;
	end

endmodule

@@ rtl/core/ltc_queue.sv @@
// Short request queue between the front and back ends.
module ltc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  ltc_pkg::event_t wr_data,
	output logic            full,
	input  logic            rd,
	output ltc_pkg::event_t rd_data,
	output logic            empty
);
	import ltc_pkg::*;

	event_t                 mem_q [EVQ_DEPTH];
	logic [EVQ_PTR_W-1:0]   wptr_q, rptr_q;
	logic [EVQ_CNT_W-1:0]   cnt_q;
	logic                   do_wr, do_rd;

	assign full    = (cnt_q == EVQ_CNT_W'(EVQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + EVQ_PTR_W'(1);
			if (do_rd)
				rptr_q <= rptr_q + EVQ_PTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + EVQ_CNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - EVQ_CNT_W'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

endmodule

@@ rtl/core/ltc_back.sv @@
// Back end: expands each request into one or two results behind an output register.
module ltc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ev_empty,
	input  ltc_pkg::event_t    ev_data,
	output logic               ev_pop,
	output logic               empty,
	input  logic               pop,
	output ltc_pkg::out_item_t result
);
	import ltc_pkg::*;

	out_item_t res_q;
	logic      valid_q;
	logic      op_next_q;   // token half of the head request already sent
	logic      load, send_tok;

	assign empty    = !valid_q;
	assign result   = res_q;
	assign load     = !valid_q || pop;
	assign send_tok = ev_data.has_tok && !op_next_q;
	assign ev_pop   = !ev_empty && load && !(send_tok && ev_data.has_op);

	// Output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			op_next_q <= 1'b0;
		end else if (load) begin
			valid_q <= !ev_empty;
			if (!ev_empty)
				op_next_q <= send_tok && ev_data.has_op;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load && !ev_empty) begin
			if (send_tok) begin
				res_q.token_kind   <= ev_data.tok_kind;
				res_q.symbol_char  <= 8'h00;
				res_q.token_length <= ev_data.tok_len;
				res_q.last_of_run  <= !ev_data.has_op;
			end else begin
				res_q.token_kind   <= KIND_OPER;
				res_q.symbol_char  <= ev_data.op_char;
				res_q.token_length <= LEN_W'(1);
				res_q.last_of_run  <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/lexical_token_classifier_top.sv @@
// Top level of the lexical token classifier.
//
//  channel  | signals               | direction | request taken when
//  ---------+-----------------------+-----------+--------------------
//  item     | push, full, item      | in        | push && !full
//  result   | empty, pop, result    | out       | pop && !empty
//
// One character is taken per cycle while the four-entry request queue has room.
// The front classifies in the cycle of acceptance; the request then passes through
// the request queue and the output register before it reaches the result ports.
// The back end sends one result per cycle while results are popped, so a delimiter
// that closes a token and is an operator yields two results, the token first.
// Reset empties the queue and clears the pending token's count and flags and the output valid flag.
// A stalled result side fills the queue, after which full holds off the input.
module lexical_token_classifier_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  ltc_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output ltc_pkg::out_item_t result
);
	import ltc_pkg::*;

	logic   ev_push, ev_full, ev_pop, ev_empty;
	event_t ev_wr, ev_rd;

	ltc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.ev_push (ev_push),
		.ev_data (ev_wr),
		.ev_full (ev_full)
	);

	ltc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (ev_push),
		.wr_data (ev_wr),
		.full    (ev_full),
		.rd      (ev_pop),
		.rd_data (ev_rd),
		.empty   (ev_empty)
	);

	ltc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_empty (ev_empty),
		.ev_data  (ev_rd),
		.ev_pop   (ev_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
